>>> rtl/djs_pkg.sv
package djs_pkg;

  // Field widths
  localparam int DUR_W        = 32;
  localparam int INC_W        = 32;
  localparam int TIME_W       = 43;
  localparam int SUM_W        = TIME_W + 1;
  localparam int KEPT_W       = 11;
  localparam int MAX_JOBS_DEF = 1024;

  // Result action codes
  typedef enum logic [1:0] {
    ACT_REJECT  = 2'd0,
    ACT_APPEND  = 2'd1,
    ACT_REPLACE = 2'd2,
    ACT_FULL    = 2'd3
  } action_t;

  typedef struct packed {
    logic             first_job;
    logic [DUR_W-1:0] duration;
    logic [INC_W-1:0] deadline_increment;
  } in_word_t;

  typedef struct packed {
    logic [KEPT_W-1:0] jobs_kept;
    action_t           action;
  } out_word_t;

  // Sequencer of the job-level bookkeeping
  typedef enum logic [2:0] {
    S_IDLE,
    S_DEADLINE,
    S_FIT,
    S_SUB,
    S_SWAP,
    S_HEAP,
    S_FINISH
  } main_state_t;

  // Sequencer of the heap sift walk
  typedef enum logic [2:0] {
    H_IDLE,
    H_UP_RD,
    H_UP_CMP,
    H_DN_L,
    H_DN_R,
    H_DN_CMP
  } heap_state_t;

  // Command from the bookkeeping sequencer to the heap
  typedef struct packed {
    logic             clear;
    logic             push;
    logic             replace;
    logic [DUR_W-1:0] value;
  } heap_cmd_t;

  // Heap status back to the bookkeeping sequencer
  typedef struct packed {
    logic             busy;
    logic [DUR_W-1:0] top;
  } heap_stat_t;

endpackage

>>> rtl/deadline_job_selector_core.sv
// Deadline job selector: keeps the largest set of jobs that all meet their
// running deadlines, one job per input word, with a max-heap of kept durations.
// Input channel in_valid/in_stall/in_data carries one job word; output channel
// out_valid/out_stall/out_data carries one result word per job (kept count and
// action). A word moves on a rising edge with valid high and stall low.
// One job at a time: in_stall is high from acceptance until the result has
// been loaded into the output register. A shared 44-bit add/subtract unit does
// the deadline sum, the fit test, the subtraction of the longest job and the
// swap test in successive cycles, then the heap sifts through its memory with
// one read port: per heap level it reads the parent and compares on an append,
// and reads the left child, reads the right child and compares on a replace;
// a reject or a full result goes from the tests straight to the result word.
// The output register lets the next job be accepted while a result is still
// waiting; if a second result is ready while out_stall holds the first, the
// sequencer waits and keeps in_stall high. Reset empties the heap, clears busy
// time and deadline and drops any pending result; heap memory needs no clearing.
module deadline_job_selector_core import djs_pkg::*; #(
  parameter int MAX_JOBS = MAX_JOBS_DEF
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_word_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_word_t out_data
);

  localparam int SW = $clog2(MAX_JOBS + 1);

  main_state_t       state, state_next;
  logic [TIME_W-1:0] busy, busy_next;
  logic [TIME_W-1:0] deadline, deadline_next;
  logic [SUM_W-1:0]  acc, acc_next;
  logic [DUR_W-1:0]  dur, dur_next;
  logic [INC_W-1:0]  inc, inc_next;
  action_t           act, act_next;
  logic              out_valid_next;
  out_word_t         out_data_next;

  heap_cmd_t         cmd;
  heap_stat_t        stat;
  logic [SW-1:0]     size;
  logic [SW+KEPT_W-1:0] size_wide;

  logic [SUM_W-1:0]  add_a, add_b, sum;
  logic              add_sub;
  logic              fits;
  logic              full;

  djs_heap #(.MAX_JOBS(MAX_JOBS)) u_heap (
    .clk  (clk),
    .rst  (rst),
    .cmd  (cmd),
    .stat (stat),
    .size (size)
  );

  // Shared adder/subtractor and deadline compare
  assign sum  = add_a + (add_sub ? ~add_b : add_b) + {{(SUM_W - 1){1'b0}}, add_sub};
  assign fits = (sum <= {1'b0, deadline});
  assign full = (size == SW'(MAX_JOBS));

  assign size_wide = {{KEPT_W{1'b0}}, size};
  assign in_stall  = rst || (state != S_IDLE);

  // Job sequencer
  always_comb begin
    state_next     = state;
    busy_next      = busy;
    deadline_next  = deadline;
    acc_next       = acc;
    dur_next       = dur;
    inc_next       = inc;
    act_next       = act;
    out_valid_next = out_valid && out_stall;
    out_data_next  = out_data;
    cmd            = '0;
    cmd.value      = dur;
    add_a          = {1'b0, busy};
    add_b          = {{(SUM_W - DUR_W){1'b0}}, dur};
    add_sub        = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          dur_next = in_data.duration;
          inc_next = in_data.deadline_increment;
          if (in_data.first_job) begin
            busy_next     = '0;
            deadline_next = '0;
            cmd.clear     = 1'b1;
          end
          state_next = S_DEADLINE;
        end
      end
      S_DEADLINE: begin
        // advance the running deadline, saturating
        add_a         = {1'b0, deadline};
        add_b         = {{(SUM_W - INC_W){1'b0}}, inc};
        deadline_next = sum[TIME_W] ? '1 : sum[TIME_W-1:0];
        state_next    = S_FIT;
      end
      S_FIT: begin
        if (fits) begin
          if (full) begin
            act_next   = ACT_FULL;
            state_next = S_FINISH;
          end else begin
            busy_next  = sum[TIME_W-1:0];
            cmd.push   = 1'b1;
            act_next   = ACT_APPEND;
            state_next = S_HEAP;
          end
        end else if ((size != '0) && (dur < stat.top)) begin
          state_next = S_SUB;
        end else begin
          act_next   = ACT_REJECT;
          state_next = S_FINISH;
        end
      end
      S_SUB: begin
        // drop the longest kept job from the busy time
        add_b      = {{(SUM_W - DUR_W){1'b0}}, stat.top};
        add_sub    = 1'b1;
        acc_next   = sum;
        state_next = S_SWAP;
      end
      S_SWAP: begin
        add_a = acc;
        if (fits) begin
          busy_next   = sum[TIME_W-1:0];
          cmd.replace = 1'b1;
          act_next    = ACT_REPLACE;
          state_next  = S_HEAP;
        end else begin
          act_next   = ACT_REJECT;
          state_next = S_FINISH;
        end
      end
      S_HEAP: begin
        if (!stat.busy) begin
          state_next = S_FINISH;
        end
      end
      S_FINISH: begin
        // load the result word once the output register is free
        if (!out_valid || !out_stall) begin
          out_valid_next          = 1'b1;
          out_data_next.jobs_kept = size_wide[KEPT_W-1:0];
          out_data_next.action    = act;
          state_next              = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      busy      <= '0;
      deadline  <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      busy      <= busy_next;
      deadline  <= deadline_next;
      out_valid <= out_valid_next;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    acc      <= acc_next;
    dur      <= dur_next;
    inc      <= inc_next;
    act      <= act_next;
    out_data <= out_data_next;
  end

endmodule

>>> rtl/djs_heap.sv
module djs_heap import djs_pkg::*; #(
  parameter int  MAX_JOBS = MAX_JOBS_DEF,
  localparam int AW       = $clog2(MAX_JOBS),
  localparam int SW       = $clog2(MAX_JOBS + 1)
) (
  input  logic             clk,
  input  logic             rst,
  input  heap_cmd_t        cmd,
  output heap_stat_t       stat,
  output logic [SW-1:0]    size
);

  // Child index width: 2*idx+2 must fit
  localparam int CW = AW + 2;

  logic [DUR_W-1:0] mem [MAX_JOBS];
  logic [DUR_W-1:0] rd_data;
  logic [DUR_W-1:0] top;

  heap_state_t      hstate, hstate_next;
  logic [AW-1:0]    idx, idx_next;
  logic [DUR_W-1:0] val, val_next;
  logic [DUR_W-1:0] left_val, left_val_next;
  logic             has_right, has_right_next;
  logic [SW-1:0]    size_next;

  logic             we;
  logic [AW-1:0]    wr_addr;
  logic [DUR_W-1:0] wr_data;
  logic [AW-1:0]    rd_addr;

  logic [CW-1:0]    child_l, child_r, size_ext;
  logic [AW-1:0]    parent;
  logic             pick_r;
  logic [DUR_W-1:0] big_val;
  logic [AW-1:0]    big_idx;

  assign child_l  = {1'b0, idx, 1'b1};
  assign child_r  = child_l + CW'(1);
  assign size_ext = {{(CW - SW){1'b0}}, size};
  assign parent   = (idx - AW'(1)) >> 1;
  assign pick_r   = has_right && (rd_data > left_val);
  assign big_val  = pick_r ? rd_data : left_val;
  assign big_idx  = pick_r ? child_r[AW-1:0] : child_l[AW-1:0];

  assign stat.busy = (hstate != H_IDLE);
  assign stat.top  = top;

  // Sift sequencer: one memory read per cycle, one write per level
  always_comb begin
    hstate_next    = hstate;
    idx_next       = idx;
    val_next       = val;
    left_val_next  = left_val;
    has_right_next = has_right;
    size_next      = size;
    we             = 1'b0;
    wr_addr        = idx;
    wr_data        = val;
    rd_addr        = '0;
    unique case (hstate)
      H_IDLE: begin
        if (cmd.clear) begin
          size_next = '0;
        end else if (cmd.push) begin
          val_next    = cmd.value;
          idx_next    = size[AW-1:0];
          size_next   = size + SW'(1);
          hstate_next = H_UP_RD;
        end else if (cmd.replace) begin
          val_next    = cmd.value;
          idx_next    = '0;
          hstate_next = H_DN_L;
        end
      end
      H_UP_RD: begin
        if (idx == '0) begin
          we          = 1'b1;
          hstate_next = H_IDLE;
        end else begin
          rd_addr     = parent;
          hstate_next = H_UP_CMP;
        end
      end
      H_UP_CMP: begin
        we = 1'b1;
        if (rd_data >= val) begin
          hstate_next = H_IDLE;
        end else begin
          wr_data     = rd_data;
          idx_next    = parent;
          hstate_next = H_UP_RD;
        end
      end
      H_DN_L: begin
        if (child_l >= size_ext) begin
          we          = 1'b1;
          hstate_next = H_IDLE;
        end else begin
          rd_addr     = child_l[AW-1:0];
          hstate_next = H_DN_R;
        end
      end
      H_DN_R: begin
        left_val_next  = rd_data;
        has_right_next = (child_r < size_ext);
        rd_addr        = child_r[AW-1:0];
        hstate_next    = H_DN_CMP;
      end
      H_DN_CMP: begin
        we = 1'b1;
        if (big_val <= val) begin
          hstate_next = H_IDLE;
        end else begin
          wr_data     = big_val;
          idx_next    = big_idx;
          hstate_next = H_DN_L;
        end
      end
      default: hstate_next = H_IDLE;
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      hstate <= H_IDLE;
      size   <= '0;
    end else begin
      hstate <= hstate_next;
      size   <= size_next;
    end
  end

  // Walk registers
  always_ff @(posedge clk) begin
    idx       <= idx_next;
    val       <= val_next;
    left_val  <= left_val_next;
    has_right <= has_right_next;
  end

  // Heap store with registered read; mirror the root for a free top read
  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
    if (we) begin
      mem[wr_addr] <= wr_data;
      if (wr_addr == '0) begin
        top <= wr_data;
      end
    end
  end

endmodule

>>> rtl/djs_checker.sv
module djs_checker import djs_pkg::*; (
  input logic      clk,
  input logic      rst,
  input logic      in_valid,
  input logic      in_stall,
  input logic      out_valid,
  input logic      out_stall,
  input out_word_t out_data
);

  // Hold a stalled result word
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result word changed while stalled");

  // Stall input right after a job word is taken
  a_one_job: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("second job taken while one is in progress");

  // Drop any result at reset
  a_reset: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid after reset");

  // Raise a new result only at the end of a busy period
  a_result_src: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result appeared without a job in progress");

endmodule

bind deadline_job_selector_core djs_checker u_djs_checker (.*);

>>> tb/deadline_job_selector_checker.sv
module deadline_job_selector_checker import djs_pkg::*; #(
  parameter int MAX_JOBS = MAX_JOBS_DEF
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  input  logic      in_stall,
  input  in_word_t  in_data,
  input  logic      out_valid,
  input  logic      out_stall,
  input  out_word_t out_data,
  output int        errors,
  output int        pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [TIME_W-1:0] DEADLINE_CAP = '1;
  localparam int PRINT_CAP = 100;

  // Predicted schedule state
  logic [DUR_W-1:0]  dur_heap [MAX_JOBS];
  int unsigned       heap_cnt = 0;
  logic [TIME_W-1:0] busy = '0;
  logic [TIME_W-1:0] deadline = '0;

  // Outcomes still owed by the block, oldest first
  out_word_t job_outcomes [$];
  out_word_t want;

  initial errors = 0;
  initial pending = 0;

  task automatic report_mismatch(input string what);
    errors++;
    if (errors <= PRINT_CAP) begin
      $display("[%0t] mismatch: %s", $realtime, what);
    end
  endtask

  // Insert a kept duration and sift it up toward the root
  function automatic void heap_insert(input logic [DUR_W-1:0] v);
    int unsigned pos;
    int unsigned parent;
    pos = heap_cnt;
    heap_cnt++;
    while (pos > 0) begin
      parent = (pos - 1) / 2;
      if (dur_heap[parent] >= v) break;
      dur_heap[pos] = dur_heap[parent];
      pos = parent;
    end
    dur_heap[pos] = v;
  endfunction

  // Overwrite the longest kept duration and sift the new value down
  function automatic void heap_swap_top(input logic [DUR_W-1:0] v);
    int unsigned pos;
    int unsigned lchild;
    int unsigned bigger;
    pos = 0;
    while (2 * pos + 1 < heap_cnt) begin
      lchild = 2 * pos + 1;
      bigger = lchild;
      if (lchild + 1 < heap_cnt && dur_heap[lchild + 1] > dur_heap[lchild]) begin
        bigger = lchild + 1;
      end
      if (dur_heap[bigger] <= v) break;
      dur_heap[pos] = dur_heap[bigger];
      pos = bigger;
    end
    dur_heap[pos] = v;
  endfunction

  // Advance the schedule by one job and return the kept count and action
  function automatic out_word_t schedule_job(input in_word_t job);
    logic [SUM_W-1:0] total;
    logic [SUM_W-1:0] swapped;
    logic [DUR_W-1:0] longest;
    out_word_t        res;
    res.action = ACT_REJECT;
    if (job.first_job) begin
      heap_cnt = 0;
      busy = '0;
      deadline = '0;
    end
    // Saturate the running deadline
    total = deadline + job.deadline_increment;
    deadline = (total > DEADLINE_CAP) ? DEADLINE_CAP : total[TIME_W-1:0];
    total = busy + job.duration;
    if (total <= deadline) begin
      if (heap_cnt >= MAX_JOBS) begin
        res.action = ACT_FULL;
      end else begin
        heap_insert(job.duration);
        busy = total[TIME_W-1:0];
        res.action = ACT_APPEND;
      end
    end else if (heap_cnt > 0) begin
      longest = dur_heap[0];
      swapped = busy - longest + job.duration;
      if (job.duration < longest && swapped <= deadline) begin
        busy = swapped[TIME_W-1:0];
        heap_swap_top(job.duration);
        res.action = ACT_REPLACE;
      end
    end
    res.jobs_kept = heap_cnt[KEPT_W-1:0];
    return res;
  endfunction

  // Check each result word against the oldest outcome, then log new jobs
  always @(posedge clk) begin
    if (rst) begin
      heap_cnt = 0;
      busy = '0;
      deadline = '0;
      job_outcomes.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (job_outcomes.size() == 0) begin
          report_mismatch($sformatf("result word with no job pending (kept %0d action %0d)",
                                    out_data.jobs_kept, out_data.action));
        end else begin
          want = job_outcomes.pop_front();
          if (out_data.jobs_kept !== want.jobs_kept || out_data.action !== want.action) begin
            report_mismatch($sformatf("kept %0d action %0d, expected kept %0d action %0d",
                                      out_data.jobs_kept, out_data.action,
                                      want.jobs_kept, want.action));
          end
        end
      end
      if (in_valid && !in_stall) begin
        job_outcomes.insert(job_outcomes.size(), schedule_job(in_data));
      end
    end
    pending <= job_outcomes.size();
  end

endmodule

>>> tb/deadline_job_selector_core_tb.sv
module deadline_job_selector_core_tb import djs_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT  = 1000000;
  localparam int RANDOM_JOBS  = 580;
  localparam int QUIET_JOBS   = 100;
  localparam int DRAIN_CYCLES = 50;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_word_t  in_data = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_word_t out_data;

  int errors;
  int pending;
  int idle_pct = 0;
  int stall_pct = 0;
  int stall_left = 0;
  int cycle_count = 0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  deadline_job_selector_core #(.MAX_JOBS(MAX_JOBS_DEF)) u_dut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  deadline_job_selector_checker #(.MAX_JOBS(MAX_JOBS_DEF)) u_checker (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data),
    .errors   (errors),
    .pending  (pending)
  );

  // Give up on a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("deadline_job_selector_core test failed");
      $finish;
    end
  end

  // Hold off result words in bursts of random length
  always @(posedge clk) begin
    if (stall_left != 0) begin
      out_stall  <= 1'b1;
      stall_left <= stall_left - 1;
    end else if (!rst && $urandom_range(99) < stall_pct) begin
      out_stall  <= 1'b1;
      stall_left <= $urandom_range(2);
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Present one job word, with an optional idle burst first, and wait for it
  task automatic send_job(input logic first, input logic [DUR_W-1:0] dur,
                          input logic [INC_W-1:0] inc);
    in_word_t job;
    job.first_job          = first;
    job.duration           = dur;
    job.deadline_increment = inc;
    if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(3, 1)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= job;
    do @(posedge clk); while (in_stall);
  endtask

  // Stop sending and wait for every owed result word
  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  initial begin
    int sent;
    int run_len;
    int i;
    logic [DUR_W-1:0] dur;
    logic [INC_W-1:0] inc;
    logic first;

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Directed jobs
    idle_pct = 30;
    stall_pct <= 30;
    send_job(1'b1, '0, '0);                     // zero job fits at zero deadline
    send_job(1'b0, '1, '0);                     // too long, not shorter than longest
    send_job(1'b1, 32'd1, '0);                  // new instance, misses with empty heap
    send_job(1'b0, 32'd10, 32'd10);
    send_job(1'b0, 32'd20, 32'd25);
    send_job(1'b0, 32'd20, '0);                 // misses, equal to longest: rejected
    send_job(1'b0, 32'd12, '0);                 // misses, shorter: replaces longest
    send_job(1'b0, '1, '1);                     // widest fields append
    send_job(1'b0, 32'd5, '0);                  // fits in the remaining slack: appends
    send_job(1'b0, '0, '0);
    send_job(1'b1, 32'h5555_5555, 32'hAAAA_AAAA);
    send_job(1'b0, 32'hAAAA_AAAA, 32'h5555_5555);
    send_job(1'b0, 32'hAAAA_AAAA, '0);
    send_job(1'b1, '1, '1);
    send_job(1'b0, '1, '0);
    send_job(1'b0, 32'h8000_0000, 32'h7FFF_FFFF);
    send_job(1'b0, 32'd1, 32'd1);
    send_job(1'b0, 32'd3, '0);
    drain_results();

    // Random instances, mostly well formed, with noise and wide values mixed in
    sent = 0;
    while (sent < RANDOM_JOBS) begin
      run_len = $urandom_range(80, 1);
      if (sent < RANDOM_JOBS - QUIET_JOBS) begin
        case ($urandom_range(2))
          0: idle_pct = 0;
          1: idle_pct = 20;
          default: idle_pct = 60;
        endcase
        case ($urandom_range(2))
          0: stall_pct <= 0;
          1: stall_pct <= 20;
          default: stall_pct <= 60;
        endcase
      end
      for (i = 0; i < run_len && sent < RANDOM_JOBS; i++) begin
        if (sent >= RANDOM_JOBS - QUIET_JOBS) begin
          idle_pct = 0;
          stall_pct <= 0;
        end
        first = (i == 0) || ($urandom_range(19) == 0);
        case ($urandom_range(9))
          0: begin
            dur = $urandom;
            inc = $urandom;
          end
          1: begin
            dur = $urandom_range(100);
            inc = $urandom;
          end
          2: begin
            dur = $urandom;
            inc = $urandom_range(120);
          end
          default: begin
            dur = $urandom_range(100);
            inc = $urandom_range(120);
          end
        endcase
        send_job(first, dur, inc);
        sent++;
      end
    end

    drain_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0 && pending == 0) begin
      $display("deadline_job_selector_core test passed");
    end else begin
      $display("deadline_job_selector_core test failed");
    end
    $finish;
  end

endmodule

>>> sim.f
rtl/djs_pkg.sv
rtl/djs_heap.sv
rtl/deadline_job_selector_core.sv
rtl/djs_checker.sv
tb/deadline_job_selector_checker.sv
tb/deadline_job_selector_core_tb.sv
